// ===== src/aimdre_pkg.sv =====
// Shared constants and types of the AIMD rate estimator.
// No dependencies; imported by aimdre_incr and aimd_rate_estimator_core.
package aimdre_pkg;

  // Field widths
  localparam int BPS_W   = 34;
  localparam int STAMP_W = 48;
  localparam int IVL_W   = 32;
  localparam int LOSS_W  = 17;
  localparam int CNT_W   = 5;
  localparam int ADD_W   = 48;
  localparam int HEAD_W  = 38;

  // Configuration register indexes
  localparam logic [2:0] CFG_LOSS_LIMIT      = 3'd0;
  localparam logic [2:0] CFG_CUT_FACTOR      = 3'd1;
  localparam logic [2:0] CFG_INCREASE_SLOPE  = 3'd2;
  localparam logic [2:0] CFG_HEADROOM_FACTOR = 3'd3;
  localparam logic [2:0] CFG_RATE_FLOOR      = 3'd4;

  // Configuration reset values
  localparam logic [15:0]      LOSS_LIMIT_RST      = 16'd6554;
  localparam logic [15:0]      CUT_FACTOR_RST      = 16'd55706;
  localparam logic [BPS_W-1:0] INCREASE_SLOPE_RST  = 34'd100000;
  localparam logic [11:0]      HEADROOM_FACTOR_RST = 12'd384;
  localparam logic [BPS_W-1:0] RATE_FLOOR_RST      = 34'd100000;

  localparam logic [BPS_W-1:0] RATE_MAX = 34'd10000000000;

  // Used-report counter saturates at the lower of this and the counter's range.
  localparam int FULL_CONFIDENCE_COUNT = 16;
  localparam logic [CNT_W-1:0] COUNT_LIMIT =
    (FULL_CONFIDENCE_COUNT > 31) ? 5'd31 : 5'(FULL_CONFIDENCE_COUNT);

  localparam logic [19:0] US_PER_S     = 20'd1000000;
  localparam logic [21:0] US_PER_S_X1  = 22'd1000000;
  localparam logic [21:0] US_PER_S_X2  = 22'd2000000;

  // floor(n / 10^6) == (n * DIV_MAGIC) >> 50 for every 32-bit n.
  localparam logic [31:0] DIV_MAGIC =
    32'(((64'd1 << 50) + 64'd999999) / 64'd1000000);
  // floor(2^54 / 10^6): quotient estimate for the fractional-second term.
  localparam logic [34:0] DIV_RECIP = 35'((64'd1 << 54) / 64'd1000000);

  // Per-report values that ride along the increase pipeline.
  typedef struct packed {
    logic              loss_p;
    logic              loss_gt;
    logic              thru_p;
    logic              cap_p;
    logic [BPS_W-1:0]  cap;
    logic [STAMP_W-1:0] stamp;
    logic [BPS_W-1:0]  dec_thru;
    logic [HEAD_W-1:0] head;
    logic [BPS_W-1:0]  seed;
  } side_t;

endpackage

// ===== src/aimdre_incr.sv =====
// Six-stage pipeline that forms floor(increase_slope * interval_us / 10^6)
// and carries each report's side values along. Depends on aimdre_pkg.
module aimdre_incr (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_ivl,
  input  aimdre_pkg::side_t   in_side,
  input  logic [33:0]         slope,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [47:0]         out_add,
  output aimdre_pkg::side_t   out_side
);
  import aimdre_pkg::*;

  logic [6:1] v;
  logic [7:1] rdy;

  // Stage registers
  logic [63:0] s1_m;
  logic [31:0] s1_ivl;
  side_t       s1_side;
  logic [12:0] s2_whole;
  logic [19:0] s2_part;
  side_t       s2_side;
  logic [46:0] s3_aw;
  logic [53:0] s3_x;
  side_t       s3_side;
  logic [63:0] s4_pp00;
  logic [34:0] s4_pp01;
  logic [37:0] s4_pp10;
  logic [8:0]  s4_pp11;
  logic [21:0] s4_xlo;
  logic [46:0] s4_aw;
  side_t       s4_side;
  logic [33:0] s5_qe;
  logic [21:0] s5_xlo;
  logic [46:0] s5_aw;
  side_t       s5_side;

  // Combinational values between stages
  logic [12:0] whole_c;
  logic [32:0] whole_us;
  logic [37:0] xh;
  logic [72:0] qsum;
  logic [41:0] qe_us;
  logic [21:0] rem;
  logic [1:0]  corr;
  logic [33:0] q;

  // A stage loads when it is empty or its content moves on this cycle.
  always_comb begin
    rdy[7] = out_ready;
    for (int k = 6; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = v[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  always_comb begin
    whole_c  = s1_m[62:50];
    whole_us = 33'(whole_c) * 33'(US_PER_S);
    xh       = s3_x[53:16];
    qsum     = 73'(s4_pp00) + (73'(s4_pp01) << 32) + (73'(s4_pp10) << 32)
             + (73'(s4_pp11) << 64);
    qe_us    = 42'(s5_qe[21:0]) * 42'(US_PER_S);
    rem      = s5_xlo - qe_us[21:0];
    // The estimate is low by at most two.
    priority if (rem >= US_PER_S_X2) corr = 2'd2;
    else if (rem >= US_PER_S_X1)     corr = 2'd1;
    else                             corr = 2'd0;
    q = s5_qe + 34'(corr);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_m    <= 64'(in_ivl) * 64'(DIV_MAGIC);
      s1_ivl  <= in_ivl;
      s1_side <= in_side;
    end
    if (rdy[2]) begin
      s2_whole <= whole_c;
      s2_part  <= 20'(s1_ivl - whole_us[31:0]);
      s2_side  <= s1_side;
    end
    if (rdy[3]) begin
      s3_aw   <= 47'(slope) * 47'(s2_whole);
      s3_x    <= 54'(slope) * 54'(s2_part);
      s3_side <= s2_side;
    end
    if (rdy[4]) begin
      s4_pp00 <= 64'(xh[31:0]) * 64'(DIV_RECIP[31:0]);
      s4_pp01 <= 35'(xh[31:0]) * 35'(DIV_RECIP[34:32]);
      s4_pp10 <= 38'(xh[37:32]) * 38'(DIV_RECIP[31:0]);
      s4_pp11 <= 9'(xh[37:32]) * 9'(DIV_RECIP[34:32]);
      s4_xlo  <= s3_x[21:0];
      s4_aw   <= s3_aw;
      s4_side <= s3_side;
    end
    if (rdy[5]) begin
      s5_qe   <= qsum[71:38];
      s5_xlo  <= s4_xlo;
      s5_aw   <= s4_aw;
      s5_side <= s4_side;
    end
    if (rdy[6]) begin
      out_add  <= 48'(s5_aw) + 48'(q);
      out_side <= s5_side;
    end
  end

endmodule

// ===== src/aimd_rate_estimator_core.sv =====
// Top level of the AIMD rate estimator: input register, increase pipeline,
// rate state update and result register. Depends on aimdre_pkg, aimdre_incr.
//
// The block takes one interval report per word and returns one result word
// per report, in order, carrying the rate, used count, valid flag and stamp
// after that report. It sustains one word per clock while the result side
// accepts words; a result word passes through the input register, six
// pipeline stages that divide the slope times interval product by 10^6 with a
// reciprocal multiply and a small correction, and the result register where
// the rate state is updated. Stalls on the result side leave earlier stages
// free to fill their bubbles. The user must write registers on the cfg port
// only while no report is in flight; the block itself does not enforce this.
module aimd_rate_estimator_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // loss_ratio[16:0], thru_bps[50:17], capacity_bps[84:51], cap_bps[118:85],
  // interval_us[150:119], stamp_in_us[198:151], zero pad [199]
  input  logic [199:0] s_axis_tdata,
  // loss_present[0], thru_present[1], capacity_present[2], cap_present[3]
  input  logic [3:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rate_out_bps[33:0], used_count[38:34], stamp_out_us[86:39], zero pad [87]
  output logic [87:0]  m_axis_tdata,
  // estimate_valid[0]
  output logic [0:0]   m_axis_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [33:0]  cfg_data
);
  import aimdre_pkg::*;

  // Configuration
  logic [15:0]      loss_limit;
  logic [15:0]      cut_factor;
  logic [BPS_W-1:0] increase_slope;
  logic [11:0]      headroom_factor;
  logic [BPS_W-1:0] rate_floor;

  // Input register
  logic               v0;
  logic               in_loss_p;
  logic [LOSS_W-1:0]  in_loss;
  logic               in_thru_p;
  logic [BPS_W-1:0]   in_thru;
  logic               in_capy_p;
  logic [BPS_W-1:0]   in_capy;
  logic               in_cap_p;
  logic [BPS_W-1:0]   in_cap;
  logic [IVL_W-1:0]   in_ivl;
  logic [STAMP_W-1:0] in_stamp;

  logic [49:0] dec_full;
  logic [45:0] head_full;
  side_t       side_in;

  logic             inc_in_ready;
  logic             inc_valid;
  logic             inc_ready;
  logic [ADD_W-1:0] inc_add;
  side_t            inc_side;
  logic             fin;

  // Rate state and result register
  logic [BPS_W-1:0]   rate;
  logic [CNT_W-1:0]   used;
  logic [STAMP_W-1:0] stamp;
  logic [BPS_W-1:0]   rate_next;
  logic [CNT_W-1:0]   used_next;
  logic [STAMP_W-1:0] stamp_next;
  logic               out_v;
  logic [BPS_W-1:0]   out_rate;
  logic [CNT_W-1:0]   out_used;
  logic [STAMP_W-1:0] out_stamp;

  logic [BPS_W-1:0] r0;
  logic [49:0]      dprod;
  logic [ADD_W-1:0] rinc;
  logic [ADD_W-1:0] r1;
  logic [ADD_W-1:0] r2;
  logic [ADD_W-1:0] r3;

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_limit      <= LOSS_LIMIT_RST;
      cut_factor      <= CUT_FACTOR_RST;
      increase_slope  <= INCREASE_SLOPE_RST;
      headroom_factor <= HEADROOM_FACTOR_RST;
      rate_floor      <= RATE_FLOOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOSS_LIMIT:      loss_limit      <= cfg_data[15:0];
        CFG_CUT_FACTOR:      cut_factor      <= cfg_data[15:0];
        CFG_INCREASE_SLOPE:  increase_slope  <= cfg_data;
        CFG_HEADROOM_FACTOR: headroom_factor <= cfg_data[11:0];
        CFG_RATE_FLOOR:      rate_floor      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !v0 || inc_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (s_axis_tready) begin
      v0 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      in_loss_p <= s_axis_tuser[0];
      in_thru_p <= s_axis_tuser[1];
      in_capy_p <= s_axis_tuser[2];
      in_cap_p  <= s_axis_tuser[3];
      in_loss   <= s_axis_tdata[16:0];
      in_thru   <= s_axis_tdata[50:17];
      in_capy   <= s_axis_tdata[84:51];
      in_cap    <= s_axis_tdata[118:85];
      in_ivl    <= s_axis_tdata[150:119];
      in_stamp  <= s_axis_tdata[198:151];
    end
  end

  // Everything that does not depend on the rate state is formed up front.
  always_comb begin
    dec_full  = 50'(cut_factor) * 50'(in_thru);
    head_full = 46'(headroom_factor) * 46'(in_thru);
    side_in.loss_p   = in_loss_p;
    side_in.loss_gt  = in_loss > {1'b0, loss_limit};
    side_in.thru_p   = in_thru_p;
    side_in.cap_p    = in_cap_p;
    side_in.cap      = in_cap;
    side_in.stamp    = in_stamp;
    side_in.dec_thru = dec_full[49:16];
    side_in.head     = head_full[45:8];
    priority if (in_thru_p && in_thru != '0) side_in.seed = in_thru;
    else if (in_capy_p)                      side_in.seed = in_capy;
    else                                     side_in.seed = rate_floor;
  end

  aimdre_incr u_incr (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .in_ready  (inc_in_ready),
    .in_ivl    (in_ivl),
    .in_side   (side_in),
    .slope     (increase_slope),
    .out_valid (inc_valid),
    .out_ready (inc_ready),
    .out_add   (inc_add),
    .out_side  (inc_side)
  );

  assign inc_ready = !out_v || m_axis_tready;
  assign fin       = inc_valid && inc_ready;

  always_comb begin
    r0    = (used == '0) ? inc_side.seed : rate;
    dprod = 50'(r0) * 50'(cut_factor);
    rinc  = 48'(r0) + inc_add;
    if (inc_side.loss_gt) begin
      if (inc_side.thru_p) begin
        r1 = (inc_side.dec_thru < r0) ? 48'(inc_side.dec_thru) : 48'(r0);
      end else begin
        r1 = 48'(dprod[49:16]);
      end
    end else begin
      r1 = (inc_side.thru_p && 48'(inc_side.head) < rinc) ? 48'(inc_side.head) : rinc;
    end
    r2 = (inc_side.cap_p && 48'(inc_side.cap) < r1) ? 48'(inc_side.cap) : r1;
    r3 = (r2 < 48'(rate_floor)) ? 48'(rate_floor) : r2;
    if (inc_side.loss_p) begin
      rate_next  = (r3 > 48'(RATE_MAX)) ? RATE_MAX : r3[BPS_W-1:0];
      used_next  = (used < COUNT_LIMIT) ? used + 5'd1 : used;
      stamp_next = inc_side.stamp;
    end else begin
      rate_next  = rate;
      used_next  = used;
      stamp_next = stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate  <= '0;
      used  <= '0;
      stamp <= '0;
      out_v <= 1'b0;
    end else begin
      if (inc_ready) out_v <= inc_valid;
      if (fin) begin
        rate  <= rate_next;
        used  <= used_next;
        stamp <= stamp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_rate  <= rate_next;
      out_used  <= used_next;
      out_stamp <= stamp_next;
    end
  end

  assign m_axis_tvalid   = out_v;
  assign m_axis_tdata    = {1'b0, out_stamp, out_used, out_rate};
  assign m_axis_tuser[0] = out_used != '0;

  // A report without a loss ratio must not disturb the estimate.
  a_ignored_report: assert property (@(posedge clk) disable iff (rst)
    (fin && !inc_side.loss_p) |=> ($stable(rate) && $stable(used) && $stable(stamp)))
    else $error("ignored report changed the rate state");

  // The used count only ever steps up by one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && used != $past(used)) |-> (used == $past(used) + 5'd1))
    else $error("used count moved by other than one");

  a_rate_limit: assert property (@(posedge clk) disable iff (rst)
    rate <= RATE_MAX)
    else $error("rate above saturation limit");

  // Every finished word shows the state it left behind.
  a_result_state: assert property (@(posedge clk) disable iff (rst)
    fin |=> (m_axis_tvalid && out_rate == rate && out_used == used))
    else $error("result word does not match rate state");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for aimd_rate_estimator_core: a directed table of reports,
// then randomized report streams under several register settings and idle patterns.
// Depends on aimdre_pkg and the RTL under src.
module tb;
  import aimdre_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int PRESSURE_HOLD = 300;

  typedef struct packed {
    logic               loss_p;
    logic [LOSS_W-1:0]  loss;
    logic               thru_p;
    logic [BPS_W-1:0]   thru;
    logic               capy_p;
    logic [BPS_W-1:0]   capy;
    logic               cap_p;
    logic [BPS_W-1:0]   cap;
    logic [IVL_W-1:0]   ivl;
    logic [STAMP_W-1:0] stamp;
  } report_t;

  typedef struct packed {
    logic [BPS_W-1:0]   rate;
    logic [CNT_W-1:0]   used;
    logic               valid;
    logic [STAMP_W-1:0] stamp;
  } estimate_t;

  typedef struct {
    report_t   rp;
    bit        typed;
    estimate_t want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [199:0] s_axis_tdata = '0;
  logic [3:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [33:0]  cfg_data = '0;

  // Shadow copy of the register file.
  logic [15:0]      cur_loss_thr = LOSS_LIMIT_RST;
  logic [15:0]      cur_dec      = CUT_FACTOR_RST;
  logic [BPS_W-1:0] cur_slope    = INCREASE_SLOPE_RST;
  logic [11:0]      cur_head     = HEADROOM_FACTOR_RST;
  logic [BPS_W-1:0] cur_floor    = RATE_FLOOR_RST;

  // Shadow copy of the estimator state.
  logic [BPS_W-1:0]   est_rate  = '0;
  logic [CNT_W-1:0]   est_used  = '0;
  logic [STAMP_W-1:0] est_stamp = '0;

  estimate_t pending_estimates[$];
  stim_row_t stim_table[$];

  int  sender_idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  failures = 0;
  int  words_in = 0;
  int  ignored_in = 0;
  int  words_out = 0;
  int  settings_count = 0;
  int  cycle_count = 0;

  aimd_rate_estimator_core DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one report to the shadow state and returns the estimate it leaves behind.
  function automatic estimate_t next_estimate(input report_t rp);
    logic [63:0] r;
    logic [63:0] whole;
    logic [63:0] part;
    logic [63:0] bound;
    estimate_t   e;
    if (rp.loss_p) begin
      r = 64'(est_rate);
      if (est_used == '0) begin
        if (rp.thru_p && rp.thru != '0) r = 64'(rp.thru);
        else if (rp.capy_p) r = 64'(rp.capy);
        else r = 64'(cur_floor);
      end
      if (rp.loss > cur_loss_thr) begin
        if (rp.thru_p) begin
          bound = (64'(cur_dec) * 64'(rp.thru)) >> 16;
          if (bound < r) r = bound;
        end else begin
          r = (r * 64'(cur_dec)) >> 16;
        end
      end else begin
        // The slope times interval product is split at whole seconds, as the block does.
        whole = 64'(rp.ivl) / 64'(US_PER_S);
        part  = 64'(rp.ivl) % 64'(US_PER_S);
        r = r + 64'(cur_slope) * whole + (64'(cur_slope) * part) / 64'(US_PER_S);
        if (rp.thru_p) begin
          bound = (64'(cur_head) * 64'(rp.thru)) >> 8;
          if (bound < r) r = bound;
        end
      end
      if (rp.cap_p && 64'(rp.cap) < r) r = 64'(rp.cap);
      if (r < 64'(cur_floor)) r = 64'(cur_floor);
      if (r > 64'(RATE_MAX)) r = 64'(RATE_MAX);
      est_rate = r[BPS_W-1:0];
      if (est_used < COUNT_LIMIT) est_used = est_used + 1'b1;
      est_stamp = rp.stamp;
    end
    e.rate  = est_rate;
    e.used  = est_used;
    e.valid = (est_used != '0);
    e.stamp = est_stamp;
    return e;
  endfunction

  function automatic logic [BPS_W-1:0] rand_bps();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return BPS_W'({$urandom, $urandom});
      3: return RATE_MAX;
      4, 5: return BPS_W'($urandom_range(1000000, 1));
      6: return BPS_W'({$urandom, $urandom} % 64'd10000000001);
      default: return BPS_W'($urandom_range(1000000000, 0));
    endcase
  endfunction

  task automatic add_row(input logic lp, input logic [LOSS_W-1:0] loss,
                         input logic tp, input logic [BPS_W-1:0] thru,
                         input logic cp, input logic [BPS_W-1:0] capy,
                         input logic kp, input logic [BPS_W-1:0] cap,
                         input logic [IVL_W-1:0] ivl, input logic [STAMP_W-1:0] stamp);
    stim_row_t row;
    row.rp    = '{lp, loss, tp, thru, cp, capy, kp, cap, ivl, stamp};
    row.typed = 1'b0;
    row.want  = '0;
    stim_table.push_back(row);
  endtask

  // Types in the expected estimate for the row added last.
  task automatic add_want(input logic [BPS_W-1:0] rate, input logic [CNT_W-1:0] used,
                          input logic [STAMP_W-1:0] stamp);
    stim_table[stim_table.size()-1].typed = 1'b1;
    stim_table[stim_table.size()-1].want  = '{rate, used, used != '0, stamp};
  endtask

  task automatic send_report(input report_t rp, input bit typed, input estimate_t want);
    estimate_t e;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, rp.stamp, rp.ivl, rp.cap, rp.capy, rp.thru, rp.loss};
    s_axis_tuser  <= {rp.cap_p, rp.capy_p, rp.thru_p, rp.loss_p};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    e = next_estimate(rp);
    pending_estimates.push_back(typed ? want : e);
    words_in++;
    if (!rp.loss_p) ignored_in++;
  endtask

  task automatic wait_drained();
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [33:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [33:0] thr, input logic [33:0] dec,
                               input logic [33:0] slope, input logic [33:0] head,
                               input logic [33:0] flr);
    write_reg(CFG_LOSS_LIMIT, thr);
    write_reg(CFG_CUT_FACTOR, dec);
    write_reg(CFG_INCREASE_SLOPE, slope);
    write_reg(CFG_HEADROOM_FACTOR, head);
    write_reg(CFG_RATE_FLOOR, flr);
    cfg_we <= 1'b0;
    cur_loss_thr = thr[15:0];
    cur_dec      = dec[15:0];
    cur_slope    = slope[BPS_W-1:0];
    cur_head     = head[11:0];
    cur_floor    = flr[BPS_W-1:0];
    settings_count++;
  endtask

  task automatic load_random_settings();
    load_settings(34'($urandom_range(65535, 1)), 34'($urandom_range(65535, 1)),
                  $urandom_range(1) ? 34'($urandom_range(1000000, 1))
                                    : 34'({$urandom, $urandom} % 64'd10000000000 + 64'd1),
                  34'($urandom_range(2560, 256)), 34'($urandom_range(2000000, 0)));
  endtask

  // Sends random reports until n of them carried a loss ratio.
  task automatic run_phase(input int n, input int idle, input int stall, input bit pressure);
    report_t rp;
    int      used_sent;
    int      thr;
    used_sent = 0;
    sender_idle_pct = idle;
    stall_pct = stall;
    while (used_sent < n) begin
      thr = int'(cur_loss_thr);
      rp.loss_p = ($urandom_range(9) != 0);
      case ($urandom_range(9))
        0: rp.loss = '0;
        1: rp.loss = LOSS_W'(65536);
        2: rp.loss = LOSS_W'(thr);
        3: rp.loss = LOSS_W'(thr + 1);
        4, 5, 6: rp.loss = LOSS_W'($urandom_range(thr, 0));
        default: rp.loss = LOSS_W'($urandom_range(65536, thr + 1));
      endcase
      rp.thru_p = ($urandom_range(9) < 7);
      rp.thru   = rand_bps();
      rp.capy_p = 1'($urandom_range(1));
      rp.capy   = rand_bps();
      rp.cap_p  = ($urandom_range(9) < 3);
      rp.cap    = rand_bps();
      case ($urandom_range(9))
        0: rp.ivl = '0;
        1: rp.ivl = '1;
        2: rp.ivl = $urandom;
        3: rp.ivl = IVL_W'(999999);
        4: rp.ivl = IVL_W'(1000000);
        default: rp.ivl = IVL_W'($urandom_range(3000000, 0));
      endcase
      rp.stamp = STAMP_W'({$urandom, $urandom});
      if (pressure && used_sent == 10) hold_req = 1'b1;
      send_report(rp, 1'b0, '0);
      if (rp.loss_p) used_sent++;
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();
  endtask

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    failures++;
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
  endtask

  // Result side: random stalls, plus one long hold-off that backs up the pipeline.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = PRESSURE_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_estimates
    estimate_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (pending_estimates.size() == 0) begin
        failures++;
        $display("%0t: unexpected word, expected none, got rate %0d used %0d", $time,
                 m_axis_tdata[33:0], m_axis_tdata[38:34]);
      end else begin
        want = pending_estimates.pop_front();
        if (m_axis_tdata[33:0] !== want.rate)
          report_field("rate_out_bps", 64'(want.rate), 64'(m_axis_tdata[33:0]));
        if (m_axis_tdata[38:34] !== want.used)
          report_field("used_count", 64'(want.used), 64'(m_axis_tdata[38:34]));
        if (m_axis_tuser[0] !== want.valid)
          report_field("estimate_valid", 64'(want.valid), 64'(m_axis_tuser[0]));
        if (m_axis_tdata[86:39] !== want.stamp)
          report_field("stamp_out_us", 64'(want.stamp), 64'(m_axis_tdata[86:39]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    // Ignored report right after reset: the state is still all zeros.
    add_row(1'b0, 17'd65536, 1'b1, 34'd5000, 1'b1, 34'd7000, 1'b1, 34'd9000, 32'd1, 48'h123);
    add_want(34'd0, 5'd0, 48'd0);
    // First used report seeds from the capacity since no throughput is given.
    add_row(1'b1, 17'd0, 1'b0, 34'd0, 1'b1, 34'd3000000000, 1'b0, 34'd0, 32'd0, 48'd1000);
    add_want(34'd3000000000, 5'd1, 48'd1000);
    add_row(1'b0, 17'd0, 1'b1, 34'd1, 1'b1, 34'd1, 1'b1, 34'd1, 32'd1, 48'd5555);
    add_want(34'd3000000000, 5'd1, 48'd1000);
    // Loss equal to the threshold still counts as an increase.
    add_row(1'b1, 17'd6554, 1'b0, 34'd0, 1'b0, 34'd0, 1'b0, 34'd0, 32'd1000000, 48'd2000);
    add_want(34'd3000100000, 5'd2, 48'd2000);
    add_row(1'b1, 17'd6555, 1'b0, 34'd0, 1'b0, 34'd0, 1'b0, 34'd0, 32'd0, 48'd3000);
    add_row(1'b1, 17'd65536, 1'b1, 34'd1000000000, 1'b0, 34'd0, 1'b0, 34'd0, 32'd0, 48'd4000);
    // A present zero throughput drives the cut, and the headroom cap, to the floor.
    add_row(1'b1, 17'd30000, 1'b1, 34'd0, 1'b0, 34'd0, 1'b0, 34'd0, 32'd0, 48'd7000);
    add_want(34'd100000, 5'd5, 48'd7000);
    add_row(1'b1, 17'd0, 1'b1, 34'd0, 1'b0, 34'd0, 1'b0, 34'd0, 32'hFFFF_FFFF, 48'd8000);
    add_want(34'd100000, 5'd6, 48'd8000);
    add_row(1'b1, 17'd0, 1'b0, 34'd0, 1'b0, 34'd0, 1'b0, 34'd0, 32'hFFFF_FFFF, 48'd9000);
    add_row(1'b1, 17'd0, 1'b0, 34'd0, 1'b0, 34'd0, 1'b1, 34'd0, 32'd5000, 48'd10000);
    add_want(34'd100000, 5'd8, 48'd10000);
    add_row(1'b1, 17'd0, 1'b1, 34'd10000000000, 1'b0, 34'd0, 1'b1, 34'd10000000000,
            32'd0, 48'd11000);
    add_row(1'b1, 17'd0, 1'b1, 34'h3_FFFF_FFFF, 1'b1, 34'h3_FFFF_FFFF, 1'b0, 34'd0,
            32'hFFFF_FFFF, 48'd12000);
    add_row(1'b1, 17'd65535, 1'b0, 34'd0, 1'b1, 34'd1, 1'b0, 34'd0, 32'd0, 48'hFFFF_FFFF_FFFF);
    add_row(1'b1, 17'd0, 1'b0, 34'd0, 1'b0, 34'd0, 1'b0, 34'd0, 32'd999999, 48'd14000);
    add_row(1'b1, 17'd0, 1'b0, 34'd0, 1'b0, 34'd0, 1'b0, 34'd0, 32'd1000000, 48'd15000);
    add_row(1'b0, 17'h1_FFFF, 1'b1, 34'h3_FFFF_FFFF, 1'b1, 34'h3_FFFF_FFFF, 1'b1,
            34'h3_FFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_row(1'b1, 17'd0, 1'b0, 34'd0, 1'b0, 34'd0, 1'b0, 34'd0, 32'd0, 48'd0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) send_report(stim_table[i].rp, stim_table[i].typed,
                                        stim_table[i].want);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    load_settings(34'd1, 34'd1, 34'd1, 34'd256, 34'd0);
    run_phase(78, 0, 0, 1'b0);
    load_settings(34'd65535, 34'd65535, 34'd10000000000, 34'd2560, 34'd10000000000);
    run_phase(78, 61, 0, 1'b0);
    load_random_settings();
    run_phase(78, 0, 61, 1'b1);
    // Values beyond the documented ranges; upper bits of a narrow register are dropped.
    load_settings(34'h3_0001_0000, 34'd0, 34'h3_FFFF_FFFF, 34'd4095, 34'h3_FFFF_FFFF);
    run_phase(78, 12, 12, 1'b0);
    load_settings(34'(LOSS_LIMIT_RST), 34'(CUT_FACTOR_RST), INCREASE_SLOPE_RST,
                  34'(HEADROOM_FACTOR_RST), RATE_FLOOR_RST);
    run_phase(78, 61, 0, 1'b0);
    load_random_settings();
    run_phase(78, 0, 61, 1'b0);
    load_random_settings();
    run_phase(78, 12, 12, 1'b0);
    load_random_settings();
    run_phase(78, 0, 0, 1'b0);

    $display("Covered %0d reports (%0d without loss ratio) under %0d register settings;",
             words_in, ignored_in, settings_count);
    $display("%0d estimate words checked, %0d mismatches.", words_out, failures);
    if (failures == 0 && pending_estimates.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
